// ----- rtl/core/nscm_pkg.sv -----
`timescale 1ns / 1ps

package nscm_pkg;

	localparam int CoordW    = 24;
	localparam int DistW     = 23;
	localparam int WeightW   = 16;
	localparam int CostW     = 32;
	localparam int CountW    = 13;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 24;
	localparam int InDataW   = 240;
	localparam int OutDataW  = 56;

	localparam int MaxNeighbors = 4096;
	localparam int CountCap     = (MaxNeighbors > 8191) ? 8191 : MaxNeighbors;
	localparam int AtanEntries  = 24;
	localparam int CordicSteps  = (16 < AtanEntries) ? 16 : AtanEntries;
	localparam int StepW        = 5;

	localparam logic [CfgIdxW-1:0] CFG_ANGLE_W  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DIST_W   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SPEED_W  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_BIAS     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_RADIUS   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_SPD_THR  = 3'd5;

	localparam logic [1:0] CAUSE_CLOSE = 2'b01;
	localparam logic [1:0] CAUSE_COST  = 2'b10;

	// atan(2^-i) in units of 2^-24 rad
	function automatic logic [23:0] atan_lut(input logic [StepW-1:0] i);
		logic [23:0] v;
		begin
			case (i)
				5'd0:  v = 24'd13176795;
				5'd1:  v = 24'd7778716;
				5'd2:  v = 24'd4110060;
				5'd3:  v = 24'd2086331;
				5'd4:  v = 24'd1047214;
				5'd5:  v = 24'd524117;
				5'd6:  v = 24'd262123;
				5'd7:  v = 24'd131069;
				5'd8:  v = 24'd65536;
				5'd9:  v = 24'd32768;
				5'd10: v = 24'd16384;
				5'd11: v = 24'd8192;
				5'd12: v = 24'd4096;
				5'd13: v = 24'd2048;
				5'd14: v = 24'd1024;
				5'd15: v = 24'd512;
				5'd16: v = 24'd256;
				5'd17: v = 24'd128;
				5'd18: v = 24'd64;
				5'd19: v = 24'd32;
				5'd20: v = 24'd16;
				5'd21: v = 24'd8;
				5'd22: v = 24'd4;
				5'd23: v = 24'd2;
				default: v = 24'd0;
			endcase
			return v;
		end
	endfunction

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_SPD  = 14'b00000000000010,
		ST_SQS  = 14'b00000000000100,
		ST_DOT  = 14'b00000000001000,
		ST_DST  = 14'b00000000010000,
		ST_SQD  = 14'b00000000100000,
		ST_CRS  = 14'b00000001000000,
		ST_NRM  = 14'b00000010000000,
		ST_CSQ  = 14'b00000100000000,
		ST_SQC  = 14'b00001000000000,
		ST_COR  = 14'b00010000000000,
		ST_CST  = 14'b00100000000000,
		ST_CFN  = 14'b01000000000000,
		ST_FIN  = 14'b10000000000000
	} state_t;

endpackage

// ----- rtl/core/neighbor_stop_cost_monitor.sv -----
`timescale 1ns / 1ps

// Obstacle stop monitor.
// Input stream: one obstacle point per request. s_tdata holds the vehicle position,
// velocity, the point and the nearest distance; s_tuser flags that a point is present;
// s_tlast closes an evaluation. Output stream: one result per closed evaluation.
// Configuration: cfg_we writes register cfg_index with cfg_data. Each request is
// worked on alone by one shared 32x32 multiplier, one bit-serial square root unit
// and one CORDIC shift-add stage. A request ends early when the vehicle is slow,
// the point is absent or the point lies behind; a relevant point goes on through
// operand scaling, the CORDIC and the cost, and its three square roots take most
// of its time. s_tready is high only while idle.
// A result sits in an output register; if the receiver stalls, the request that
// closes an evaluation waits there in its final state before the next is taken.
// Reset clears the evaluation state and loads the register defaults; no clearing
// pass is needed.
module neighbor_stop_cost_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, point_x, point_y, point_z, nearest_distance
	input  logic [nscm_pkg::InDataW-1:0]      s_tdata,
	// point_valid
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// stop, stop_cause, least_cost, relevant_count, any_relevant, below_speed
	output logic [nscm_pkg::OutDataW-1:0]     m_tdata,
	input  logic                              cfg_we,
	input  logic [nscm_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [nscm_pkg::CfgDataW-1:0]     cfg_data
);
	import nscm_pkg::*;

	state_t state_q;

	logic [WeightW-1:0] aw_q, dw_q, sw_q;
	logic [CoordW-1:0]  bias_q;
	logic [DistW-1:0]   radius_q, thr_q;

	logic signed [CostW-1:0] least_q;
	logic [CountW-1:0]       count_q;
	logic                    any_q;

	logic signed [CoordW-1:0] vx_q, vy_q, vz_q;
	logic signed [CoordW:0]   ox_q, oy_q, oz_q;
	logic                     pv_q, last_q, slow_q;
	logic [DistW-1:0]         near_q;
	logic [CoordW-1:0]        speed_q;
	logic [CoordW:0]          dist_q;

	logic [2:0]               k_q;
	logic                     ph_q;
	logic signed [63:0]       prod_q, acc_q;
	logic signed [31:0]       mul_a, mul_b;
	logic                     op_first, op_neg, op_sh;
	logic [2:0]               k_last;
	logic signed [63:0]       term, acc_next;

	logic [63:0]              sq_rad_q, sq_root_q, sq_b, sq_t, sq_root_n, sq_rad_n;
	logic [StepW-1:0]         sq_j_q;

	logic [49:0]              dotn_q;
	logic [49:0]              c_q [3];
	logic                     nrm_big;

	logic signed [34:0]       x_q, y_q, cdx, cdy;
	logic signed [26:0]       z_q, z_n;
	logic [StepW-1:0]         i_q;
	logic [25:0]              ang;

	logic signed [63:0]       wide;
	logic signed [43:0]       cost_full;
	logic signed [CostW-1:0]  cost;

	logic                     out_valid_q;
	logic [OutDataW-1:0]      out_q;
	logic                     fin_go;
	logic                     out_load;
	logic                     res_close, res_neg;
	logic [OutDataW-1:0]      res_word;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		op_first = 1'b0;
		op_neg = 1'b0;
		op_sh = 1'b0;
		k_last = 3'd2;
		case (state_q)
			ST_SPD: begin
				op_first = (k_q == 3'd0);
				case (k_q)
					3'd0: begin mul_a = 32'(vx_q); mul_b = 32'(vx_q); end
					3'd1: begin mul_a = 32'(vy_q); mul_b = 32'(vy_q); end
					default: begin mul_a = 32'(vz_q); mul_b = 32'(vz_q); end
				endcase
			end
			ST_DOT: begin
				op_first = (k_q == 3'd0);
				case (k_q)
					3'd0: begin mul_a = 32'(ox_q); mul_b = 32'(vx_q); end
					3'd1: begin mul_a = 32'(oy_q); mul_b = 32'(vy_q); end
					default: begin mul_a = 32'(oz_q); mul_b = 32'(vz_q); end
				endcase
			end
			ST_DST: begin
				op_first = (k_q == 3'd0);
				case (k_q)
					3'd0: begin mul_a = 32'(ox_q); mul_b = 32'(ox_q); end
					3'd1: begin mul_a = 32'(oy_q); mul_b = 32'(oy_q); end
					default: begin mul_a = 32'(oz_q); mul_b = 32'(oz_q); end
				endcase
			end
			ST_CRS: begin
				k_last = 3'd5;
				op_first = ~k_q[0];
				op_neg = k_q[0];
				case (k_q)
					3'd0: begin mul_a = 32'(oy_q); mul_b = 32'(vz_q); end
					3'd1: begin mul_a = 32'(oz_q); mul_b = 32'(vy_q); end
					3'd2: begin mul_a = 32'(oz_q); mul_b = 32'(vx_q); end
					3'd3: begin mul_a = 32'(ox_q); mul_b = 32'(vz_q); end
					3'd4: begin mul_a = 32'(ox_q); mul_b = 32'(vy_q); end
					default: begin mul_a = 32'(oy_q); mul_b = 32'(vx_q); end
				endcase
			end
			ST_CSQ: begin
				op_first = (k_q == 3'd0);
				case (k_q)
					3'd0: begin mul_a = {2'b00, c_q[0][29:0]}; mul_b = {2'b00, c_q[0][29:0]}; end
					3'd1: begin mul_a = {2'b00, c_q[1][29:0]}; mul_b = {2'b00, c_q[1][29:0]}; end
					default: begin
						mul_a = {2'b00, c_q[2][29:0]};
						mul_b = {2'b00, c_q[2][29:0]};
					end
				endcase
			end
			ST_CST: begin
				op_first = (k_q == 3'd0);
				case (k_q)
					3'd0: begin mul_a = {16'd0, aw_q}; mul_b = {6'd0, ang}; end
					3'd1: begin
						mul_a = {16'd0, dw_q};
						mul_b = {7'd0, dist_q};
						op_sh = 1'b1;
					end
					default: begin
						mul_a = {16'd0, sw_q};
						mul_b = {8'd0, speed_q};
						op_sh = 1'b1;
						op_neg = 1'b1;
					end
				endcase
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign term     = op_sh ? (prod_q <<< 12) : prod_q;
	assign acc_next = (op_first ? 64'sd0 : acc_q) + (op_neg ? -term : term);

	assign sq_b = 64'd1 << {sq_j_q, 1'b0};
	assign sq_t = sq_root_q + sq_b;
	always_comb begin
		if (sq_rad_q >= sq_t) begin
			sq_rad_n  = sq_rad_q - sq_t;
			sq_root_n = (sq_root_q >> 1) + sq_b;
		end else begin
			sq_rad_n  = sq_rad_q;
			sq_root_n = sq_root_q >> 1;
		end
	end

	assign nrm_big = (|dotn_q[49:30]) | (|c_q[0][49:30]) | (|c_q[1][49:30]) | (|c_q[2][49:30]);

	assign cdx = y_q >>> i_q;
	assign cdy = x_q >>> i_q;
	assign z_n = y_q[34] ? (z_q - 27'(atan_lut(i_q))) : (z_q + 27'(atan_lut(i_q)));
	assign ang = z_q[26] ? 26'd0 : z_q[25:0];

	assign wide      = acc_q - ({{40{bias_q[CoordW-1]}}, bias_q} <<< 20);
	assign cost_full = 44'(wide >>> 20);
	always_comb begin
		if (cost_full > 44'sd2147483647)
			cost = 32'sh7FFFFFFF;
		else if (cost_full < -44'sd2147483648)
			cost = 32'sh80000000;
		else
			cost = cost_full[CostW-1:0];
	end

	assign fin_go   = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_FIN) && last_q && fin_go;

	assign res_close = (near_q < radius_q);
	assign res_neg   = any_q && least_q[CostW-1];
	always_comb begin
		res_word = '0;
		if (slow_q) begin
			res_word[49] = 1'b1;
		end else begin
			res_word[0] = res_close | res_neg;
			res_word[2:1] = {res_neg, res_close};
			res_word[34:3] = any_q ? least_q : '0;
			res_word[47:35] = count_q;
			res_word[48] = any_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= 16'd256;
			dw_q <= 16'd256;
			sw_q <= 16'd256;
			bias_q <= '0;
			radius_q <= 23'd4096;
			thr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANGLE_W: aw_q <= cfg_data[WeightW-1:0];
				CFG_DIST_W:  dw_q <= cfg_data[WeightW-1:0];
				CFG_SPEED_W: sw_q <= cfg_data[WeightW-1:0];
				CFG_BIAS:    bias_q <= cfg_data;
				CFG_RADIUS:  radius_q <= cfg_data[DistW-1:0];
				CFG_SPD_THR: thr_q <= cfg_data[DistW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			ph_q <= 1'b0;
			least_q <= 32'sh7FFFFFFF;
			count_q <= '0;
			any_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						k_q <= '0;
						ph_q <= 1'b0;
						state_q <= ST_SPD;
					end
				end
				ST_SPD, ST_DOT, ST_DST, ST_CRS, ST_CSQ, ST_CST: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (k_q == k_last) begin
							k_q <= '0;
							case (state_q)
								ST_SPD: state_q <= ST_SQS;
								ST_DOT: state_q <= (acc_next > 64'sd0) ? ST_DST : ST_FIN;
								ST_DST: state_q <= ST_SQD;
								ST_CRS: state_q <= ST_NRM;
								ST_CSQ: state_q <= ST_SQC;
								default: state_q <= ST_CFN;
							endcase
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				ST_SQS: begin
					if (sq_j_q == '0)
						state_q <= (pv_q && !(sq_root_n[CoordW-1:0] < {1'b0, thr_q}))
							? ST_DOT : ST_FIN;
				end
				ST_SQD: begin
					if (sq_j_q == '0)
						state_q <= ST_CRS;
				end
				ST_NRM: begin
					if (!nrm_big)
						state_q <= ST_CSQ;
				end
				ST_SQC: begin
					if (sq_j_q == '0)
						state_q <= ST_COR;
				end
				ST_COR: begin
					if (i_q == StepW'(CordicSteps - 1))
						state_q <= ST_CST;
				end
				ST_CFN: begin
					if (cost < least_q)
						least_q <= cost;
					if (count_q < CountW'(CountCap))
						count_q <= count_q + 1'b1;
					any_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (fin_go) begin
						least_q <= 32'sh7FFFFFFF;
						count_q <= '0;
						any_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			vx_q <= s_tdata[95:72];
			vy_q <= s_tdata[119:96];
			vz_q <= s_tdata[143:120];
			ox_q <= 25'(signed'(s_tdata[167:144])) - 25'(signed'(s_tdata[23:0]));
			oy_q <= 25'(signed'(s_tdata[191:168])) - 25'(signed'(s_tdata[47:24]));
			oz_q <= 25'(signed'(s_tdata[215:192])) - 25'(signed'(s_tdata[71:48]));
			near_q <= s_tdata[238:216];
			pv_q <= s_tuser;
			last_q <= s_tlast;
		end
		if (!ph_q)
			prod_q <= mul_a * mul_b;
		else
			acc_q <= acc_next;
		if (state_q == ST_CRS && ph_q && k_q[0])
			c_q[k_q[2:1]] <= acc_next[63] ? 50'(-acc_next) : acc_next[49:0];
		if (ph_q && k_q == k_last &&
		    (state_q == ST_SPD || state_q == ST_DST || state_q == ST_CSQ)) begin
			sq_rad_q <= acc_next;
			sq_root_q <= '0;
			sq_j_q <= 5'd31;
		end else if (state_q == ST_SQS || state_q == ST_SQD || state_q == ST_SQC) begin
			sq_rad_q <= sq_rad_n;
			sq_root_q <= sq_root_n;
			sq_j_q <= sq_j_q - 1'b1;
		end
		if (state_q == ST_SQS && sq_j_q == '0) begin
			speed_q <= sq_root_n[CoordW-1:0];
			slow_q <= sq_root_n[CoordW-1:0] < {1'b0, thr_q};
		end
		if (state_q == ST_DOT && ph_q && k_q == k_last)
			dotn_q <= acc_next[49:0];
		if (state_q == ST_SQD && sq_j_q == '0)
			dist_q <= sq_root_n[CoordW:0];
		if (state_q == ST_NRM && nrm_big) begin
			dotn_q <= dotn_q >> 1;
			c_q[0] <= c_q[0] >> 1;
			c_q[1] <= c_q[1] >> 1;
			c_q[2] <= c_q[2] >> 1;
		end
		if (state_q == ST_SQC && sq_j_q == '0) begin
			x_q <= {5'd0, dotn_q[29:0]};
			y_q <= 35'(sq_root_n[31:0]);
			z_q <= '0;
			i_q <= '0;
		end
		if (state_q == ST_COR) begin
			if (y_q[34]) begin
				x_q <= x_q - cdx;
				y_q <= y_q + cdy;
			end else begin
				x_q <= x_q + cdx;
				y_q <= y_q - cdy;
			end
			z_q <= z_n;
			i_q <= i_q + 1'b1;
		end
		if (out_load)
			out_q <= res_word;
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import nscm_pkg::*;

	localparam int  HalfPeriod = 4;
	localparam longint CycleLimit = 6000000;
	localparam int  SettleCycles = 250;

	typedef struct {
		logic signed [CoordW-1:0] pos_x, pos_y, pos_z;
		logic signed [CoordW-1:0] vel_x, vel_y, vel_z;
		logic signed [CoordW-1:0] pt_x, pt_y, pt_z;
		logic                     pt_valid;
		logic [DistW-1:0]         nearest;
		logic                     last;
	} point_req_t;

	typedef struct {
		logic              stop;
		logic [1:0]        cause;
		logic [CostW-1:0]  cost;
		logic [CountW-1:0] count;
		logic              any;
		logic              below;
	} verdict_t;

	typedef struct {
		point_req_t req;
		logic       fixed;
		verdict_t   want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	neighbor_stop_cost_monitor uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #HalfPeriod clk = ~clk;

	// shadow registers and evaluation state
	logic [WeightW-1:0]        sh_angle_w, sh_dist_w, sh_speed_w;
	logic signed [CoordW-1:0]  sh_bias;
	logic [DistW-1:0]          sh_radius, sh_thr;
	longint                    least_seen;
	int                        relevant_seen;
	logic                      any_seen;

	verdict_t verdicts_due[$];
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  fail_count = 0;
	int  verdicts_seen = 0;
	int  reqs_sent = 0;
	int  stops_seen = 0;
	longint cycle_count = 0;

	const longint atan_steps[24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned abs64(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned length3(longint a, longint b, longint c);
		longint unsigned x, y, z;
		x = abs64(a);
		y = abs64(b);
		z = abs64(c);
		return root_floor(x * x + y * y + z * z);
	endfunction

	function automatic longint heading_angle(longint unsigned cx, longint unsigned cy,
			longint unsigned cz, longint unsigned dot);
		longint unsigned m;
		int s;
		longint x, y, z, dx, dy;
		m = dot;
		s = 0;
		z = 0;
		if (cx > m) m = cx;
		if (cy > m) m = cy;
		if (cz > m) m = cz;
		while ((m >> s) >= (64'd1 << 30)) s++;
		cx = cx >> s;
		cy = cy >> s;
		cz = cz >> s;
		x = longint'(dot >> s);
		y = longint'(root_floor(cx * cx + cy * cy + cz * cz));
		for (int i = 0; i < CordicSteps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + atan_steps[i];
			end else begin
				x = x - dx; y = y + dy; z = z - atan_steps[i];
			end
		end
		return (z < 0) ? 0 : z;
	endfunction

	function automatic logic predict_verdict(point_req_t r, output verdict_t v);
		longint vx, vy, vz, ox, oy, oz, dot, ang, wide, cost;
		longint unsigned speed, span;
		logic slow;
		vx = r.vel_x; vy = r.vel_y; vz = r.vel_z;
		speed = length3(vx, vy, vz);
		slow = speed < longint'(sh_thr);
		v = '{default: '0};
		if (r.pt_valid && !slow) begin
			ox = longint'(r.pt_x) - longint'(r.pos_x);
			oy = longint'(r.pt_y) - longint'(r.pos_y);
			oz = longint'(r.pt_z) - longint'(r.pos_z);
			dot = ox * vx + oy * vy + oz * vz;
			if (dot > 0) begin
				span = length3(ox, oy, oz);
				ang = heading_angle(abs64(oy * vz - oz * vy), abs64(oz * vx - ox * vz),
					abs64(ox * vy - oy * vx), dot);
				wide = longint'(sh_angle_w) * ang
					+ longint'(longint'(sh_dist_w) * span) * 4096
					- longint'(longint'(sh_speed_w) * speed) * 4096
					- longint'(sh_bias) * 1048576;
				cost = wide >>> 20;
				if (cost > 64'sd2147483647) cost = 64'sd2147483647;
				if (cost < -64'sd2147483648) cost = -64'sd2147483648;
				if (cost < least_seen) least_seen = cost;
				if (relevant_seen < CountCap) relevant_seen++;
				any_seen = 1'b1;
			end
		end
		if (!r.last) return 1'b0;
		if (slow) begin
			v.below = 1'b1;
		end else begin
			if (r.nearest < sh_radius) v.cause = v.cause | CAUSE_CLOSE;
			if (any_seen && least_seen < 0) v.cause = v.cause | CAUSE_COST;
			v.stop = v.cause != 2'b00;
			v.cost = any_seen ? least_seen[CostW-1:0] : '0;
			v.count = relevant_seen[CountW-1:0];
			v.any = any_seen;
		end
		least_seen = 64'sd2147483647;
		relevant_seen = 0;
		any_seen = 1'b0;
		return 1'b1;
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ANGLE_W: sh_angle_w = val[WeightW-1:0];
			CFG_DIST_W:  sh_dist_w = val[WeightW-1:0];
			CFG_SPEED_W: sh_speed_w = val[WeightW-1:0];
			CFG_BIAS:    sh_bias = val;
			CFG_RADIUS:  sh_radius = val[DistW-1:0];
			CFG_SPD_THR: sh_thr = val[DistW-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(int aw, int dw, int sw, int bias, int rad, int thr);
		write_reg(CFG_ANGLE_W, CfgDataW'(aw));
		write_reg(CFG_DIST_W, CfgDataW'(dw));
		write_reg(CFG_SPEED_W, CfgDataW'(sw));
		write_reg(CFG_BIAS, CfgDataW'(bias));
		write_reg(CFG_RADIUS, CfgDataW'(rad));
		write_reg(CFG_SPD_THR, CfgDataW'(thr));
	endtask

	task automatic drain;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// enter and leave at a falling edge
	task automatic send_req(point_req_t r, logic fixed, verdict_t want);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {1'b0, r.nearest, r.pt_z, r.pt_y, r.pt_x,
			r.vel_z, r.vel_y, r.vel_x, r.pos_z, r.pos_y, r.pos_x};
		s_tuser = r.pt_valid;
		s_tlast = r.last;
		do @(posedge clk); while (!s_tready);
		if (predict_verdict(r, v)) verdicts_due = {verdicts_due, (fixed ? want : v)};
		reqs_sent++;
		@(negedge clk);
	endtask

	function automatic point_req_t mk(int px, int py, int pz, int vx, int vy, int vz,
			int qx, int qy, int qz, logic pv, int nd, logic lst);
		point_req_t r;
		r.pos_x = CoordW'(px); r.pos_y = CoordW'(py); r.pos_z = CoordW'(pz);
		r.vel_x = CoordW'(vx); r.vel_y = CoordW'(vy); r.vel_z = CoordW'(vz);
		r.pt_x = CoordW'(qx); r.pt_y = CoordW'(qy); r.pt_z = CoordW'(qz);
		r.pt_valid = pv; r.nearest = DistW'(nd); r.last = lst;
		return r;
	endfunction

	function automatic logic signed [CoordW-1:0] coord(int sc);
		int lim;
		if (sc >= 3) return CoordW'($urandom);
		lim = 1 << (6 * sc + 8);
		return CoordW'(int'($urandom_range(2 * lim)) - lim);
	endfunction

	task automatic random_burst(int n);
		point_req_t r;
		verdict_t none;
		int len, sc;
		none = '{default: '0};
		while (n > 0) begin
			len = $urandom_range(1, 8);
			sc = $urandom_range(0, 3);
			r.pos_x = coord(sc); r.pos_y = coord(sc); r.pos_z = coord(sc);
			r.vel_x = coord($urandom_range(0, 3));
			r.vel_y = coord($urandom_range(0, 3));
			r.vel_z = coord($urandom_range(0, 3));
			for (int k = 0; k < len; k++) begin
				r.pt_x = r.pos_x + coord(sc);
				r.pt_y = r.pos_y + coord(sc);
				r.pt_z = r.pos_z + coord(sc);
				if ($urandom_range(19) == 0) r.pt_x = r.pos_x;
				r.pt_valid = ($urandom_range(9) != 0);
				r.nearest = ($urandom_range(1) != 0) ? DistW'($urandom)
					: DistW'($urandom_range(2 * sh_radius));
				r.last = (k == len - 1) || ($urandom_range(29) == 0);
				if ($urandom_range(11) == 0) r.vel_x = coord($urandom_range(0, 3));
				send_req(r, 1'b0, none);
				n--;
			end
		end
		s_tvalid = 1'b0;
	endtask

	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.stop = m_tdata[0];
			got.cause = m_tdata[2:1];
			got.cost = m_tdata[34:3];
			got.count = m_tdata[47:35];
			got.any = m_tdata[48];
			got.below = m_tdata[49];
			verdicts_seen++;
			if (got.stop) stops_seen++;
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = verdicts_due.pop_front();
				if (got.stop !== want.stop || got.cause !== want.cause
						|| got.cost !== want.cost || got.count !== want.count
						|| got.any !== want.any || got.below !== want.below) begin
					$display("%0t: mismatch exp stop=%b cause=%b cost=%h cnt=%0d any=%b below=%b",
						$time, want.stop, want.cause, want.cost, want.count, want.any,
						want.below);
					$display("%0t:          got stop=%b cause=%b cost=%h cnt=%0d any=%b below=%b",
						$time, got.stop, got.cause, got.cost, got.count, got.any,
						got.below);
					fail_count++;
				end
			end
		end
	end

	stim_row_t rows[$];

	function automatic void add_row(point_req_t r, logic fixed, verdict_t want);
		stim_row_t row;
		row.req = r;
		row.fixed = fixed;
		row.want = want;
		rows = {rows, row};
	endfunction

	initial begin
		verdict_t none, w;
		none = '{default: '0};
		sh_angle_w = 256; sh_dist_w = 256; sh_speed_w = 256;
		sh_bias = 0; sh_radius = 4096; sh_thr = 0;
		least_seen = 64'sd2147483647;
		relevant_seen = 0;
		any_seen = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_all(256, 256, 256, 0, 4096, 4096);
		write_reg(3'd6, 24'hFFFFFF);
		write_reg(3'd7, 24'h000001);

		w = none; w.stop = 1'b1; w.cause = CAUSE_CLOSE;
		add_row(mk(0, 0, 0, 4096, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, w);
		w = none; w.below = 1'b1;
		add_row(mk(0, 0, 0, 0, 0, 0, 4096, 0, 0, 1, 0, 1), 1'b1, w);
		add_row(mk(100, 200, 300, 8192, 0, 0, 100, 200, 300, 1, 8388607, 1),
			1'b1, none);
		add_row(mk(0, 0, 0, 8192, 0, 0, -4096, 500, 0, 1, 4096, 1), 1'b1, none);
		add_row(mk(0, 0, 0, 8192, 0, 0, 4096, 4096, 0, 1, 0, 0), 1'b0, none);
		add_row(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 1, 8388607, 0), 1'b0, none);
		add_row(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
			-8388608, -8388608, -8388608, 1, 0, 1), 1'b0, none);
		add_row(mk(0, 0, 0, 0, 4096, 0, 0, 40960, 0, 1, 4095, 1), 1'b0, none);
		add_row(mk(0, 0, 0, 4096, 4096, 0, 4096, -4095, 0, 1, 4097, 1),
			1'b0, none);
		add_row(mk(0, 0, 0, 4096, 0, 0, 1, 8388607, 0, 1, 0, 0), 1'b0, none);
		add_row(mk(0, 0, 0, 4095, 0, 0, 4096, 0, 0, 1, 0, 1), 1'b0, none);
		add_row(mk(5, -7, 9, 0, 0, -8388608, 5, -7, -8388608, 1, 8388607, 1),
			1'b0, none);
		foreach (rows[i]) send_req(rows[i].req, rows[i].fixed, rows[i].want);
		s_tvalid = 1'b0;
		drain();

		send_idle_pct = 13; recv_idle_pct = 71;
		write_all(256, 256, 256, 0, 4096, 0);
		random_burst(300);
		drain();
		write_all(65535, 65535, 0, -8388608, 8388607, 0);
		random_burst(300);
		drain();

		send_idle_pct = 71; recv_idle_pct = 13;
		write_all(0, 0, 65535, 8388607, 0, 4096);
		random_burst(300);
		drain();
		write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom, $urandom_range(8388607), $urandom_range(65536));
		random_burst(300);
		drain();

		send_idle_pct = 0; recv_idle_pct = 0;
		write_all(1, 300, 20000, 123456, 40000, 8388607);
		random_burst(250);
		drain();
		write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom, $urandom_range(8388607), 0);
		random_burst(300);
		drain();

		$display("sent %0d point requests, checked %0d verdicts (%0d stops)",
			reqs_sent, verdicts_seen, stops_seen);
		$display("covered seven register settings under three idling patterns");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- neighbor_stop_cost_monitor.f -----
rtl/core/nscm_pkg.sv
rtl/core/neighbor_stop_cost_monitor.sv
bench/testbench.sv
